>>> rtl/timer_scaler_search_core_macros.svh
// Assertion macros for the timer scaler search core.
// Needs clk and rst_n in scope at the point of use.
`ifndef TIMER_SCALER_SEARCH_CORE_MACROS_SVH
`define TIMER_SCALER_SEARCH_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TSS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tss same-cycle check failed");
`define TSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tss next-cycle check failed");
`else
`define TSS_ASSERT_IMPL(label, ante, cons)
`define TSS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/tss_pkg.sv
// Shared types, constants and the postscale reciprocal table
// for the timer scaler search core. No dependencies.
package tss_pkg;

    localparam int TARGET_W = 28;
    localparam int DIVD_W   = 35;
    localparam int TICKS_W  = 23;
    localparam int RECIP_W  = 25;
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W   = TICKS_W + RECIP_W;
    localparam int POST_W   = 5;
    localparam int PRE_W    = 3;
    localparam int PER_W    = 8;
    localparam int MPP_W    = 12;
    localparam int ACH_W    = 24;
    localparam int CNT_W    = 6;
    localparam int TX_W     = 31;
    localparam int TPROD_W  = 60;
    localparam int TICK_SHIFT = 35;

    localparam logic [TARGET_W-1:0] LIMIT_NS   = 28'd214748364;
    localparam logic [DIVD_W-1:0]   NS_SCALE   = 35'd100;
    localparam logic [DIVD_W-1:0]   ROUND_ADD  = 35'd1562;
    localparam logic [12:0]         TICK_CNS   = 13'd3125;
    localparam logic [CNT_W-1:0]    TDIV_LAST  = 6'd0;
    localparam logic [CNT_W-1:0]    DRAIN_LAST = 6'd1;
    localparam logic [PER_W:0]      PERIOD_MAX = 9'd255;

    // ticks = floor((4 * target + 62) / 125), the divide by 125 done as
    // a multiply by ceil(2^35 / 125) and a shift by 35
    localparam logic [TX_W-1:0]     TICK_BIAS  = 31'd62;
    localparam logic [28:0]         TICK_RECIP = 29'd274877907;

    typedef struct packed {
        logic              load;
        logic              tick_step;
        logic              recip_mul;
        logic              quot_mul;
        logic              rem_fix;
        logic              cand;
        logic              publish;
        logic [POST_W-1:0] post;
        logic [PRE_W-1:0]  pre;
    } cmd_t;

    typedef struct packed {
        logic over_limit;
    } sts_t;

    // floor(2^24 / post)
    function automatic logic [RECIP_W-1:0] recip(input logic [POST_W-1:0] post);
        logic [RECIP_W-1:0] r;
        case (post)
            5'd1:    r = 25'd16777216;
            5'd2:    r = 25'd8388608;
            5'd3:    r = 25'd5592405;
            5'd4:    r = 25'd4194304;
            5'd5:    r = 25'd3355443;
            5'd6:    r = 25'd2796202;
            5'd7:    r = 25'd2396745;
            5'd8:    r = 25'd2097152;
            5'd9:    r = 25'd1864135;
            5'd10:   r = 25'd1677721;
            5'd11:   r = 25'd1525201;
            5'd12:   r = 25'd1398101;
            5'd13:   r = 25'd1290555;
            5'd14:   r = 25'd1198372;
            5'd15:   r = 25'd1118481;
            5'd16:   r = 25'd1048576;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/tss_ctrl.sv
// Sequencer for the timer scaler search: walks the tick divide, the
// postscale and prescale loops, drain and output. Uses tss_pkg.
module tss_ctrl #(
    parameter int POSTSCALE_MAX = 16,
    parameter int PRESCALE_MAX  = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          m_tready,
    output logic          m_tvalid,
    input  tss_pkg::sts_t sts,
    output tss_pkg::cmd_t cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_TDIV  = 4'd1;
    localparam logic [3:0] ST_RMUL  = 4'd2;
    localparam logic [3:0] ST_QMUL  = 4'd3;
    localparam logic [3:0] ST_RFIX  = 4'd4;
    localparam logic [3:0] ST_CAND  = 4'd5;
    localparam logic [3:0] ST_DRAIN = 4'd6;
    localparam logic [3:0] ST_OUT   = 4'd7;

    localparam logic [tss_pkg::POST_W-1:0] POST_TOP = tss_pkg::POST_W'(POSTSCALE_MAX);
    localparam logic [tss_pkg::PRE_W-1:0]  PRE_TOP  = tss_pkg::PRE_W'(PRESCALE_MAX);

    logic [3:0]                   state_reg, state_next;
    logic [tss_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [tss_pkg::POST_W-1:0]   post_reg, post_next;
    logic [tss_pkg::PRE_W-1:0]    pre_reg, pre_next;
    logic                         m_tvalid_reg, m_tvalid_next;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        post_next     = post_reg;
        pre_next      = pre_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        cmd.post      = post_reg;
        cmd.pre       = pre_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_TDIV;
                    cnt_next   = '0;
                    post_next  = POST_TOP;
                    pre_next   = PRE_TOP;
                end
            end
            ST_TDIV:
            begin
                if (sts.over_limit)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.tick_step = 1'b1;
                    if (cnt_reg == tss_pkg::TDIV_LAST)
                    begin
                        state_next = ST_RMUL;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_RMUL:
            begin
                cmd.recip_mul = 1'b1;
                state_next    = ST_QMUL;
            end
            ST_QMUL:
            begin
                cmd.quot_mul = 1'b1;
                state_next   = ST_RFIX;
            end
            ST_RFIX:
            begin
                cmd.rem_fix = 1'b1;
                state_next  = ST_CAND;
            end
            ST_CAND:
            begin
                cmd.cand = 1'b1;
                if (pre_reg == '0)
                begin
                    pre_next = PRE_TOP;
                    if (post_reg == tss_pkg::POST_W'(1))
                    begin
                        state_next = ST_DRAIN;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        post_next  = post_reg - 1'b1;
                        state_next = ST_RMUL;
                    end
                end
                else
                begin
                    pre_next = pre_reg - 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg == tss_pkg::DRAIN_LAST)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.publish   = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            post_reg     <= POST_TOP;
            pre_reg      <= PRE_TOP;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            post_reg     <= post_next;
            pre_reg      <= pre_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

>>> rtl/tss_dpath.sv
// Datapath of the timer scaler search: reciprocal tick divide, reciprocal
// postscale divide, candidate pipe, best tracker. Uses tss_pkg.
module tss_dpath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tss_pkg::cmd_t                  cmd,
    output tss_pkg::sts_t                  sts,
    input  logic [tss_pkg::TARGET_W-1:0]   target_ns,
    output logic                           found,
    output logic [2:0]                     prescale_code,
    output logic [3:0]                     postscale_code,
    output logic [7:0]                     period_code,
    output logic [tss_pkg::ACH_W-1:0]      achieved_ns
);

    localparam int TW = tss_pkg::TARGET_W;
    localparam int KW = tss_pkg::TICKS_W;

    logic [TW-1:0]                  target_reg;
    logic [tss_pkg::TX_W-1:0]       tx_reg;
    logic [KW-1:0]                  ticks_reg;
    logic [KW-1:0]                  q0_reg, qp_reg, rem_reg;

    logic                           v1_reg, v2_reg;
    logic [tss_pkg::PER_W-1:0]      per1_reg, per2_reg;
    logic [tss_pkg::PRE_W-1:0]      pre1_reg, pre2_reg;
    logic [tss_pkg::POST_W-1:0]     post1_reg, post2_reg;
    logic [tss_pkg::MPP_W-1:0]      m1_reg;
    logic [tss_pkg::ACH_W-1:0]      t2_reg;
    logic [TW-1:0]                  err2_reg;

    logic                           best_found_reg;
    logic [TW-1:0]                  best_err_reg;
    logic [tss_pkg::ACH_W-1:0]      best_t_reg;
    logic [tss_pkg::PER_W-1:0]      best_per_reg;
    logic [tss_pkg::PRE_W-1:0]      best_pre_reg;
    logic [tss_pkg::POST_W-1:0]     best_post_reg;

    logic [KW-1:0]                  ticks;
    logic [tss_pkg::TPROD_W-1:0]    tprod;
    logic [tss_pkg::PROD_W-1:0]     prod;
    logic [27:0]                    qp_full;
    logic [KW-1:0]                  r_left;
    logic [KW:0]                    per_w;
    logic                           per_ok;
    logic [12:0]                    m_full;
    logic [18:0]                    m125;
    logic [25:0]                    t_sh;
    logic [tss_pkg::ACH_W-1:0]      t_now;
    logic [TW-1:0]                  t_ext;
    logic                           better;

    assign sts.over_limit = (target_reg > tss_pkg::LIMIT_NS);
    assign ticks          = ticks_reg;

    assign tprod = tss_pkg::TPROD_W'(tx_reg) * tss_pkg::TPROD_W'(tss_pkg::TICK_RECIP);

    assign prod    = tss_pkg::PROD_W'(ticks) * tss_pkg::PROD_W'(tss_pkg::recip(cmd.post));
    assign qp_full = 28'(q0_reg) * 28'(cmd.post);
    assign r_left  = ticks - qp_reg;

    always_comb
    begin
        if (cmd.pre == '0)
        begin
            per_w = {1'b0, rem_reg};
        end
        else
        begin
            per_w = (({1'b0, rem_reg} >> (cmd.pre - 3'd1)) + 1'b1) >> 1;
        end
    end

    assign per_ok = (per_w != '0) && (per_w <= (KW+1)'(tss_pkg::PERIOD_MAX))
                    && ((per_w > (KW+1)'(1)) || (cmd.pre != '0));
    assign m_full = 13'(per_w[tss_pkg::PER_W-1:0]) * 13'(cmd.post);

    assign m125  = 19'(m1_reg) * 19'd125;
    assign t_sh  = 26'(m125) << pre1_reg;
    assign t_now = t_sh[25:2];
    assign t_ext = TW'(t_now);

    assign better = v2_reg && (err2_reg < best_err_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.cand && per_ok;
            v2_reg <= v1_reg;
            if (cmd.load)
            begin
                best_found_reg <= 1'b0;
            end
            else if (better)
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            target_reg <= target_ns;
            tx_reg     <= tss_pkg::TX_W'({target_ns, 2'b00}) + tss_pkg::TICK_BIAS;
        end
        if (cmd.tick_step)
        begin
            ticks_reg <= tprod[tss_pkg::TICK_SHIFT +: KW];
        end

        if (cmd.recip_mul)
        begin
            q0_reg <= prod[tss_pkg::RECIP_SHIFT +: KW];
        end
        if (cmd.quot_mul)
        begin
            qp_reg <= qp_full[KW-1:0];
        end
        if (cmd.rem_fix)
        begin
            rem_reg <= (r_left >= KW'(cmd.post)) ? q0_reg + 1'b1 : q0_reg;
        end

        per1_reg  <= per_w[tss_pkg::PER_W-1:0];
        pre1_reg  <= cmd.pre;
        post1_reg <= cmd.post;
        m1_reg    <= m_full[tss_pkg::MPP_W-1:0];

        per2_reg  <= per1_reg;
        pre2_reg  <= pre1_reg;
        post2_reg <= post1_reg;
        t2_reg    <= t_now;
        err2_reg  <= (t_ext >= target_reg) ? t_ext - target_reg : target_reg - t_ext;

        if (cmd.load)
        begin
            best_err_reg  <= target_ns;
            best_t_reg    <= '0;
            best_per_reg  <= '0;
            best_pre_reg  <= '0;
            best_post_reg <= '0;
        end
        else if (better)
        begin
            best_err_reg  <= err2_reg;
            best_t_reg    <= t2_reg;
            best_per_reg  <= per2_reg;
            best_pre_reg  <= pre2_reg;
            best_post_reg <= post2_reg;
        end

        if (cmd.publish)
        begin
            found <= best_found_reg;
            if (best_found_reg)
            begin
                prescale_code  <= best_pre_reg;
                postscale_code <= 4'(best_post_reg - 1'b1);
                period_code    <= best_per_reg - 1'b1;
                achieved_ns    <= best_t_reg;
            end
            else
            begin
                prescale_code  <= '0;
                postscale_code <= '0;
                period_code    <= '0;
                achieved_ns    <= '0;
            end
        end
    end

endmodule

>>> rtl/timer_scaler_search_core.sv
// Finds timer prescale, postscale and period settings for a target interval
// in ns. Takes one target and returns one result: it takes the target, does one
// reciprocal multiply to 31.25 ns ticks, then per postscale value a reciprocal
// divide (reciprocal multiply, quotient multiply, remainder fix) and one candidate
// step per prescale value, then the pipeline drain and the output write. Targets
// above 214748364 ns return found = 0. A finished result waits in the output
// register while the next target is taken in.
// Depends on tss_pkg, tss_ctrl, tss_dpath and timer_scaler_search_core_macros.svh.
`include "timer_scaler_search_core_macros.svh"

module timer_scaler_search_core #(
    parameter int POSTSCALE_MAX = 16,
    parameter int PRESCALE_MAX  = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [27:0] target_ns, [31:28] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [2:0] prescale_code, [6:3] postscale_code,
                                   // [14:7] period_code, [38:15] achieved_ns, [39] zero
    output logic        m_tuser    // [0] found
);

    tss_pkg::cmd_t                 cmd;
    tss_pkg::sts_t                 sts;
    logic [2:0]                    prescale_code;
    logic [3:0]                    postscale_code;
    logic [7:0]                    period_code;
    logic [tss_pkg::ACH_W-1:0]     achieved_ns;

    tss_ctrl #(
        .POSTSCALE_MAX (POSTSCALE_MAX),
        .PRESCALE_MAX  (PRESCALE_MAX)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    tss_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .target_ns      (s_tdata[tss_pkg::TARGET_W-1:0]),
        .found          (m_tuser),
        .prescale_code  (prescale_code),
        .postscale_code (postscale_code),
        .period_code    (period_code),
        .achieved_ns    (achieved_ns)
    );

    assign m_tdata = {1'b0, achieved_ns, period_code, postscale_code, prescale_code};

    `TSS_ASSERT_NEXT(a_busy_after_transfer, s_tvalid && s_tready, !s_tready)
    `TSS_ASSERT_IMPL(a_miss_is_zero, m_tvalid && !m_tuser, m_tdata == 40'd0)
    `TSS_ASSERT_IMPL(a_unit_period_prescaled,
        m_tvalid && m_tuser && (m_tdata[14:7] == 8'd0), m_tdata[2:0] != 3'd0)

endmodule
